FILE: sv/tlbat_pkg.sv
// shared types and constants for the tlb address translation block
package tlbat_pkg;

   localparam int VADDR_W  = 8;
   localparam int OFFSET_W = 3;
   localparam int PAGE_W   = VADDR_W - OFFSET_W;
   localparam int FRAME_W  = 5;
   localparam int STATUS_W = 3;

   typedef enum logic {
      REQ_TRANSLATE = 1'b0,
      REQ_WRITE     = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT     = 3'd0,
      ST_MISS    = 3'd1,
      ST_FAULT   = 3'd2,
      ST_RANGE   = 3'd3,
      ST_WRITTEN = 3'd4
   } status_type;

   typedef struct packed {
      logic               en;
      logic [PAGE_W-1:0]  index;
      logic [FRAME_W-1:0] frame;
      logic               valid;
   } pt_wr_type;

   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] frame;
   } pt_rd_type;

   typedef struct packed {
      logic               en;
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
   } tlb_fill_type;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
   } tlb_lookup_type;

endpackage

FILE: sv/tlbat_req_if.sv
// request channel: translate or page table write word
interface tlbat_req_if;
   logic                             valid;
   logic                             ready;
   logic                             req_type;
   logic [tlbat_pkg::VADDR_W-1:0]    virt_addr;
   logic [tlbat_pkg::PAGE_W-1:0]     pt_index;
   logic [tlbat_pkg::FRAME_W-1:0]    pt_frame;
   logic                             pt_valid;

   modport source (output valid, req_type, virt_addr, pt_index, pt_frame, pt_valid,
                   input ready);
   modport sink   (input valid, req_type, virt_addr, pt_index, pt_frame, pt_valid,
                   output ready);
endinterface

FILE: sv/tlbat_rsp_if.sv
// response channel: physical address and status word
interface tlbat_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tlbat_pkg::VADDR_W-1:0]    phys_addr;
   logic [tlbat_pkg::STATUS_W-1:0]   status;

   modport source (output valid, phys_addr, status, input ready);
   modport sink   (input valid, phys_addr, status, output ready);
endinterface

FILE: sv/tlbat_page_table.sv
// register page table: one write port, one combinational read port
module tlbat_page_table #(
   parameter int PAGE_TOTAL = 32,
   parameter int FW         = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tlbat_pkg::pt_wr_type            wr,
   input  logic [tlbat_pkg::PAGE_W-1:0]    rd_page,
   output tlbat_pkg::pt_rd_type            rd
);
   import tlbat_pkg::*;

   localparam int PIW = (PAGE_TOTAL > 1) ? $clog2(PAGE_TOTAL) : 1;

   logic          valid_ff [PAGE_TOTAL];
   logic [FW-1:0] frame_ff [PAGE_TOTAL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAGE_TOTAL; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr.en) begin
         valid_ff[wr.index[PIW-1:0]] <= wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         frame_ff[wr.index[PIW-1:0]] <= wr.frame[FW-1:0];
      end
   end

   // caller only uses this for in-range pages
   always_comb begin
      rd.valid = valid_ff[rd_page[PIW-1:0]];
      rd.frame = FRAME_W'(frame_ff[rd_page[PIW-1:0]]);
   end

endmodule

FILE: sv/tlbat_tlb.sv
// fully associative tlb with fifo victim pointer
module tlbat_tlb #(
   parameter int TLB_ENTRIES = 4,
   parameter int FW          = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tlbat_pkg::PAGE_W-1:0]    lookup_page,
   input  tlbat_pkg::tlb_fill_type         fill,
   output tlbat_pkg::tlb_lookup_type       look
);
   import tlbat_pkg::*;

   localparam int VW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam logic [VW-1:0] LAST_SLOT = VW'(TLB_ENTRIES - 1);

   logic              valid_ff [TLB_ENTRIES];
   logic [PAGE_W-1:0] page_ff  [TLB_ENTRIES];
   logic [FW-1:0]     frame_ff [TLB_ENTRIES];
   logic [VW-1:0]     victim_ff;
   logic [VW-1:0]     victim_in;

   always_comb begin
      if (victim_ff == LAST_SLOT) begin
         victim_in = '0;
      end else begin
         victim_in = victim_ff + VW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         victim_ff <= '0;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (fill.en) begin
         victim_ff           <= victim_in;
         valid_ff[victim_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fill.en) begin
         page_ff[victim_ff]  <= fill.page;
         frame_ff[victim_ff] <= fill.frame[FW-1:0];
      end
   end

   // scan from the top so the lowest matching slot wins
   always_comb begin
      look.hit   = 1'b0;
      look.frame = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (page_ff[i] == lookup_page)) begin
            look.hit   = 1'b1;
            look.frame = FRAME_W'(frame_ff[i]);
         end
      end
   end

endmodule

FILE: sv/tlb_address_translation.sv
// Small MMU: translates an 8-bit virtual address (page in bits 7..3, offset in bits 2..0)
// through a fully associative TLB with FIFO replacement backed by a register page table,
// and writes page table entries on request. Each request word is registered on acceptance,
// then looked up and resolved from the input register (TLB compare, page table read, TLB fill
// and victim advance), and lands in the result register as the TLB fill and victim advance
// take effect; one word per cycle is sustained while rsp is ready, and a full result register
// that rsp does not take stalls the input. A word always sees the state left by the one before.
// Page numbers at or above PAGE_TOTAL answer status 3 with address 0. Page table writes do not
// flush the TLB, so a cached translation stays in use until its slot is replaced.
module tlb_address_translation #(
   parameter int PAGE_TOTAL  = 32,
   parameter int TLB_ENTRIES = 4,
   parameter int FRAME_BITS  = 5
) (
   input  logic         clock,
   input  logic         reset,
   tlbat_req_if.sink    req,
   tlbat_rsp_if.source  rsp
);
   import tlbat_pkg::*;

   localparam int FW = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;
   localparam logic [PAGE_W:0] PAGE_LIMIT = (PAGE_W + 1)'(PAGE_TOTAL);

   // input register
   logic                in_valid_ff;
   req_kind_type        in_type_ff;
   logic [VADDR_W-1:0]  in_vaddr_ff;
   logic [PAGE_W-1:0]   in_index_ff;
   logic [FRAME_W-1:0]  in_frame_ff;
   logic                in_pvalid_ff;

   // result register
   logic                out_valid_ff;
   logic [VADDR_W-1:0]  out_phys_ff;
   status_type          out_status_ff;

   logic                advance;
   logic [PAGE_W-1:0]   page;
   logic [OFFSET_W-1:0] offset;
   logic                page_ok;
   logic                index_ok;
   logic [VADDR_W-1:0]  phys_in;
   status_type          status_in;
   pt_wr_type           pt_wr;
   pt_rd_type           pt_rd;
   tlb_fill_type        fill;
   tlb_lookup_type      look;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_type_ff   <= req_kind_type'(req.req_type);
         in_vaddr_ff  <= req.virt_addr;
         in_index_ff  <= req.pt_index;
         in_frame_ff  <= req.pt_frame;
         in_pvalid_ff <= req.pt_valid;
      end
   end

   assign page     = in_vaddr_ff[VADDR_W-1:OFFSET_W];
   assign offset   = in_vaddr_ff[OFFSET_W-1:0];
   assign page_ok  = {1'b0, page} < PAGE_LIMIT;
   assign index_ok = {1'b0, in_index_ff} < PAGE_LIMIT;

   tlbat_page_table #(
      .PAGE_TOTAL (PAGE_TOTAL),
      .FW         (FW)
   ) u_page_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (pt_wr),
      .rd_page (page),
      .rd      (pt_rd)
   );

   tlbat_tlb #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .FW          (FW)
   ) u_tlb (
      .clock       (clock),
      .reset       (reset),
      .lookup_page (page),
      .fill        (fill),
      .look        (look)
   );

   always_comb begin
      phys_in   = '0;
      status_in = ST_RANGE;
      fill.en   = 1'b0;
      fill.page = page;
      fill.frame = pt_rd.frame;
      pt_wr.en    = 1'b0;
      pt_wr.index = in_index_ff;
      pt_wr.frame = in_frame_ff;
      pt_wr.valid = in_pvalid_ff;
      priority if (in_type_ff == REQ_WRITE) begin
         if (index_ok) begin
            status_in = ST_WRITTEN;
            pt_wr.en  = advance;
         end
      end else if (!page_ok) begin
         status_in = ST_RANGE;
      end else if (look.hit) begin
         status_in = ST_HIT;
         phys_in   = {look.frame, offset};
      end else if (pt_rd.valid) begin
         status_in = ST_MISS;
         phys_in   = {pt_rd.frame, offset};
         fill.en   = advance;
      end else begin
         status_in = ST_FAULT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_phys_ff   <= phys_in;
         out_status_ff <= status_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.phys_addr = out_phys_ff;
   assign rsp.status    = out_status_ff;

endmodule

FILE: tb/tlbat_test_pkg.sv
// translation checker class: tlb and page table predictor with expected response queue
package tlbat_test_pkg;
   import tlbat_pkg::*;

   localparam int PAGE_COUNT = 32;
   localparam int TLB_SLOTS  = 4;

   typedef struct packed {
      req_kind_type       kind;
      logic [VADDR_W-1:0] virt_addr;
      logic [PAGE_W-1:0]  pt_index;
      logic [FRAME_W-1:0] pt_frame;
      logic               pt_valid;
   } mmu_req_type;

   typedef struct packed {
      logic [VADDR_W-1:0] phys_addr;
      status_type         status;
   } mmu_rsp_type;

   class translation_checker;
      bit                 slot_valid[TLB_SLOTS];
      logic [PAGE_W-1:0]  slot_page[TLB_SLOTS];
      logic [FRAME_W-1:0] slot_frame[TLB_SLOTS];
      int                 next_victim;
      bit                 entry_valid[PAGE_COUNT];
      logic [FRAME_W-1:0] entry_frame[PAGE_COUNT];
      mmu_rsp_type        expected_translations[$];
      int unsigned        mismatches;

      // advance the predicted state by one accepted request word
      function void note_request(mmu_req_type word);
         mmu_rsp_type            expected;
         logic [PAGE_W-1:0]      page;
         logic [OFFSET_W-1:0]    offset;
         bit                     found;
         expected.phys_addr = '0;
         expected.status    = ST_RANGE;
         if (word.kind == REQ_WRITE) begin
            if (int'(word.pt_index) < PAGE_COUNT) begin
               entry_frame[word.pt_index] = word.pt_frame;
               entry_valid[word.pt_index] = word.pt_valid;
               expected.status = ST_WRITTEN;
            end
         end else begin
            page   = word.virt_addr[VADDR_W-1:OFFSET_W];
            offset = word.virt_addr[OFFSET_W-1:0];
            if (int'(page) < PAGE_COUNT) begin
               found = 1'b0;
               // lowest matching slot wins
               for (int i = 0; i < TLB_SLOTS; i++) begin
                  if (!found && slot_valid[i] && slot_page[i] == page) begin
                     found = 1'b1;
                     expected.phys_addr = {slot_frame[i], offset};
                     expected.status    = ST_HIT;
                  end
               end
               if (!found) begin
                  if (!entry_valid[page]) begin
                     expected.status = ST_FAULT;
                  end else begin
                     slot_valid[next_victim] = 1'b1;
                     slot_page[next_victim]  = page;
                     slot_frame[next_victim] = entry_frame[page];
                     next_victim = (next_victim + 1) % TLB_SLOTS;
                     expected.phys_addr = {entry_frame[page], offset};
                     expected.status    = ST_MISS;
                  end
               end
            end
         end
         expected_translations.push_back(expected);
      endfunction

      function void check_response(logic [VADDR_W-1:0] phys_addr, logic [STATUS_W-1:0] status);
         mmu_rsp_type expected;
         if (expected_translations.size() == 0) begin
            $error("unexpected response word: phys_addr %0h status %0d", phys_addr, status);
            mismatches++;
            return;
         end
         expected = expected_translations.pop_front();
         if (phys_addr !== expected.phys_addr) begin
            $error("phys_addr mismatch: expected %0h, actual %0h", expected.phys_addr, phys_addr);
            mismatches++;
         end
         if (status !== expected.status) begin
            $error("status mismatch: expected %0d, actual %0d", expected.status, status);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_translations.size();
      endfunction
   endclass

endpackage

FILE: tb/tlb_address_translation_test.sv
// top level testbench for the tlb address translation block
module tlb_address_translation_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tlbat_pkg::*;
   import tlbat_test_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_WORDS  = 350;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlbat_req_if req_ch ();
   tlbat_rsp_if rsp_ch ();

   tlb_address_translation uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   translation_checker checker_h;
   int unsigned        cycle_count = 0;
   int unsigned        send_idle_pct = 30;
   int unsigned        rcv_idle_pct  = 45;
   int unsigned        hot_base = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tlb_address_translation_test NOT OK");
         $finish;
      end
   end

   // response side: check accepted words, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         checker_h.check_response(rsp_ch.phys_addr, rsp_ch.status);
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   task automatic send_word(req_kind_type kind, logic [VADDR_W-1:0] va, logic [PAGE_W-1:0] idx,
                            logic [FRAME_W-1:0] frame, logic valid);
      mmu_req_type word;
      word.kind      = kind;
      word.virt_addr = va;
      word.pt_index  = idx;
      word.pt_frame  = frame;
      word.pt_valid  = valid;
      // idle cycle by cycle at the chosen rate
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= word.kind;
      req_ch.virt_addr <= word.virt_addr;
      req_ch.pt_index  <= word.pt_index;
      req_ch.pt_frame  <= word.pt_frame;
      req_ch.pt_valid  <= word.pt_valid;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      checker_h.note_request(word);
   endtask

   task automatic write_entry(logic [PAGE_W-1:0] idx, logic [FRAME_W-1:0] frame, logic valid);
      send_word(REQ_WRITE, VADDR_W'($urandom), idx, frame, valid);
   endtask

   task automatic translate(logic [VADDR_W-1:0] va);
      send_word(REQ_TRANSLATE, va, PAGE_W'($urandom), FRAME_W'($urandom), 1'($urandom));
   endtask

   // mostly pages from a small moving window so that hits, fills and evictions all happen
   task automatic send_random_word();
      logic [PAGE_W-1:0] page;
      if ($urandom_range(99) < 65)
         page = PAGE_W'(hot_base + $urandom_range(0, 6));
      else
         page = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
      if ($urandom_range(99) < 25)
         write_entry(page, FRAME_W'($urandom), ($urandom_range(99) < 80));
      else
         translate({page, OFFSET_W'($urandom)});
   endtask

   initial begin
      checker_h = new;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = REQ_TRANSLATE;
      req_ch.virt_addr = '0;
      req_ch.pt_index  = '0;
      req_ch.pt_frame  = '0;
      req_ch.pt_valid  = 1'b0;
      rsp_ch.ready     = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty page table faults at both ends of the address range
      translate(8'h00);
      translate(8'hFF);
      write_entry(5'd0, 5'd31, 1'b1);
      write_entry(5'd31, 5'd0, 1'b1);
      write_entry(5'd5, 5'd10, 1'b0);
      translate(8'h00);
      translate(8'h07);
      translate(8'hFF);
      translate(8'hF8);
      translate(8'h2A);
      // rewriting a cached page leaves the stale tlb entry in use
      write_entry(5'd0, 5'd3, 1'b1);
      translate(8'h05);
      write_entry(5'd1, 5'd1, 1'b1);
      write_entry(5'd2, 5'd2, 1'b1);
      write_entry(5'd3, 5'd30, 1'b1);
      // victim pointer wraps and evicts page 0
      translate(8'h08);
      translate(8'h11);
      translate(8'h1E);
      translate(8'h01);
      write_entry(5'd31, 5'd17, 1'b0);
      translate(8'hFC);
      write_entry(5'd21, 5'd21, 1'b1);
      translate(8'hAD);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 30;
               rcv_idle_pct  = 45;
            end
            1: begin
               send_idle_pct = 45;
               rcv_idle_pct  = 30;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 48 == 0)
               hot_base = $urandom_range(0, PAGE_COUNT - 7);
            send_random_word();
         end
      end
      req_ch.valid <= 1'b0;

      while (checker_h.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (checker_h.mismatches == 0 && checker_h.outstanding() == 0) begin
         $display("tlb_address_translation_test OK");
      end else begin
         $display("tlb_address_translation_test NOT OK");
      end
      $finish;
   end

endmodule

FILE: tlb_address_translation.f
sv/tlbat_pkg.sv
sv/tlbat_req_if.sv
sv/tlbat_rsp_if.sv
sv/tlbat_page_table.sv
sv/tlbat_tlb.sv
sv/tlb_address_translation.sv
tb/tlbat_test_pkg.sv
tb/tlb_address_translation_test.sv
